// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on the rising clock edge, disabled while in reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/rfcc_pkg.sv -----
`timescale 1ns / 1ps

package rfcc_pkg;

    localparam int MAX_RADIUS  = 3;
    localparam int MAX_ROW     = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int NCH       = 3;
    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int NUM_TAPS  = WIN_DEPTH;
    localparam int HW_BITS   = 2;
    localparam int TAP_BITS  = 16;
    localparam int FRAC_BITS = 14;
    localparam int PROD_BITS = SAMPLE_BITS + TAP_BITS;
    localparam int ACC_BITS  = PROD_BITS + $clog2(NUM_TAPS);
    localparam int COL_BITS  = ($clog2(MAX_ROW) > 0) ? $clog2(MAX_ROW) : 1;
    localparam int IDX_BITS  = 3;

    // register map
    localparam logic [IDX_BITS-1:0] CFG_HALF_WIDTH = 3'd0;
    localparam logic [IDX_BITS-1:0] CFG_TAP0       = 3'd1;
    localparam logic [IDX_BITS-1:0] CFG_TAP6       = 3'd7;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [NCH-1:0]             t_pixel;
    typedef t_pixel [WIN_DEPTH-1:0]        t_window;
    typedef logic signed [TAP_BITS-1:0]    t_tap;
    typedef t_tap [NUM_TAPS-1:0]           t_taps;

    typedef struct packed {
        logic [HW_BITS-1:0] half_width;
        t_taps              taps;
    } t_cfg;

    // a window state that owes one result
    typedef struct packed {
        logic vld;
        logic last;
    } t_emit;

endpackage

// ----- hdl/row_fir_three_channel_clamped_unit.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_stall     i_sample_a/b/c, i_row_end
// out       output     o_out_valid / i_out_stall   o_filtered_a/b/c, o_last_in_row
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one pixel per cycle while o_in_stall is low; a row-end pixel holds the input
// while the window flushes against the right edge
// a result is registered in turn in the window, products, sum and round stages
// synchronous active-low reset clears control state and restores the default taps
// an output stall backs up through the stage valids, so bubbles are squeezed out first

`include "assert_macros.svh"

module row_fir_three_channel_clamped_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [rfcc_pkg::SAMPLE_BITS-1:0] i_sample_a,
    input  logic signed [rfcc_pkg::SAMPLE_BITS-1:0] i_sample_b,
    input  logic signed [rfcc_pkg::SAMPLE_BITS-1:0] i_sample_c,
    input  logic                                 i_row_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [rfcc_pkg::SAMPLE_BITS-1:0] o_filtered_a,
    output logic signed [rfcc_pkg::SAMPLE_BITS-1:0] o_filtered_b,
    output logic signed [rfcc_pkg::SAMPLE_BITS-1:0] o_filtered_c,
    output logic                                 o_last_in_row,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rfcc_pkg::IDX_BITS-1:0]        i_cfg_index,
    input  logic [rfcc_pkg::TAP_BITS-1:0]        i_cfg_data
);

    rfcc_pkg::t_cfg    w_cfg;
    rfcc_pkg::t_pixel  w_pixel;
    rfcc_pkg::t_pixel  w_result;
    rfcc_pkg::t_emit   w_emit;
    rfcc_pkg::t_window w_window;
    logic              w_take;

    assign w_pixel[0]   = i_sample_a;
    assign w_pixel[1]   = i_sample_b;
    assign w_pixel[2]   = i_sample_c;
    assign o_filtered_a = w_result[0];
    assign o_filtered_b = w_result[1];
    assign o_filtered_c = w_result[2];

    rfcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rfcc_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_pixel      (w_pixel),
        .i_row_end    (i_row_end),
        .i_half_width (w_cfg.half_width),
        .i_take       (w_take),
        .o_emit       (w_emit),
        .o_window     (w_window)
    );

    rfcc_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (w_emit),
        .i_window (w_window),
        .i_cfg    (w_cfg),
        .o_take   (w_take),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_result),
        .o_last   (o_last_in_row)
    );

    // a pending window result that cannot move on must hold the input
    `ASSERT_IMPL(a_pending_holds_input, i_clk, i_rst_n, w_emit.vld && !w_take, o_in_stall)
    // an empty output register means the whole datapath can advance
    `ASSERT_IMPL(a_empty_out_takes, i_clk, i_rst_n, !o_out_valid, w_take)
    // a row end with nonzero radius starts a flush that blocks the next pixel
    `ASSERT_NEXT(a_row_end_flush, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_row_end && (w_cfg.half_width != '0), o_in_stall)

endmodule

// ----- hdl/rfcc_cfg.sv -----
`timescale 1ns / 1ps

module rfcc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfcc_pkg::IDX_BITS-1:0]  i_cfg_index,
    input  logic [rfcc_pkg::TAP_BITS-1:0]  i_cfg_data,
    output rfcc_pkg::t_cfg                 o_cfg
);

    // unity on tap one, zero on every other tap
    localparam rfcc_pkg::t_taps TAPS_RESET =
        rfcc_pkg::t_taps'(1 << (rfcc_pkg::FRAC_BITS + rfcc_pkg::TAP_BITS));

    rfcc_pkg::t_cfg                 r_cfg;
    logic [rfcc_pkg::IDX_BITS-1:0]  tap_idx;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign tap_idx     = i_cfg_index - rfcc_pkg::CFG_TAP0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width <= rfcc_pkg::HW_BITS'(1);
            r_cfg.taps       <= TAPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                rfcc_pkg::CFG_HALF_WIDTH: begin
                    r_cfg.half_width <= i_cfg_data[rfcc_pkg::HW_BITS-1:0];
                end
                [rfcc_pkg::CFG_TAP0:rfcc_pkg::CFG_TAP6]: begin
                    r_cfg.taps[tap_idx] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hdl/rfcc_window.sv -----
`timescale 1ns / 1ps

module rfcc_window (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  rfcc_pkg::t_pixel               i_pixel,
    input  logic                           i_row_end,
    input  logic [rfcc_pkg::HW_BITS-1:0]   i_half_width,
    input  logic                           i_take,
    output rfcc_pkg::t_emit                o_emit,
    output rfcc_pkg::t_window              o_window
);

    rfcc_pkg::t_window              r_win,     n_win;
    rfcc_pkg::t_emit                r_emit,    n_emit;
    logic [rfcc_pkg::COL_BITS-1:0]  r_col,     n_col;
    // flush step in progress, zero when not flushing
    logic [rfcc_pkg::HW_BITS-1:0]   r_fl_e,    n_fl_e;
    // column at row end, clamped to the radius range
    logic [rfcc_pkg::HW_BITS-1:0]   r_fl_base, n_fl_base;

    logic step_ok;
    logic flushing;
    logic in_acc;

    assign step_ok  = !r_emit.vld || i_take;
    assign flushing = (r_fl_e != '0);
    assign in_acc   = i_valid && step_ok && !flushing;
    assign o_stall  = !step_ok || flushing;
    assign o_emit   = r_emit;
    assign o_window = r_win;

    always_comb begin
        n_win     = r_win;
        n_emit    = r_emit;
        n_col     = r_col;
        n_fl_e    = r_fl_e;
        n_fl_base = r_fl_base;
        if (step_ok) begin
            n_emit.vld  = 1'b0;
            n_emit.last = 1'b0;
        end
        if (step_ok && flushing) begin
            // clamp to edge on the right: repeat the newest pixel
            n_win[0] = r_win[0];
            for (int k = 1; k < rfcc_pkg::WIN_DEPTH; k++) begin
                n_win[k] = r_win[k-1];
            end
            n_emit.vld  = ({1'b0, r_fl_base} + {1'b0, r_fl_e}) >= {1'b0, i_half_width};
            n_emit.last = (r_fl_e == i_half_width);
            n_fl_e      = (r_fl_e == i_half_width) ? '0 : r_fl_e + 1'b1;
        end else if (in_acc) begin
            if (r_col == '0) begin
                // clamp to edge on the left: first pixel fills the window
                for (int k = 0; k < rfcc_pkg::WIN_DEPTH; k++) begin
                    n_win[k] = i_pixel;
                end
            end else begin
                n_win[0] = i_pixel;
                for (int k = 1; k < rfcc_pkg::WIN_DEPTH; k++) begin
                    n_win[k] = r_win[k-1];
                end
            end
            n_emit.vld  = 32'(r_col) >= 32'(i_half_width);
            n_emit.last = i_row_end && (i_half_width == '0);
            if (i_row_end) begin
                n_col = '0;
                if (i_half_width != '0) begin
                    n_fl_e    = rfcc_pkg::HW_BITS'(1);
                    n_fl_base = (32'(r_col) >= rfcc_pkg::MAX_RADIUS)
                              ? rfcc_pkg::HW_BITS'(rfcc_pkg::MAX_RADIUS)
                              : r_col[rfcc_pkg::HW_BITS-1:0];
                end
            end else if (32'(r_col) < rfcc_pkg::MAX_ROW - 1) begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= '0;
            r_col  <= '0;
            r_fl_e <= '0;
        end else begin
            r_emit <= n_emit;
            r_col  <= n_col;
            r_fl_e <= n_fl_e;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win     <= n_win;
        r_fl_base <= n_fl_base;
    end

endmodule

// ----- hdl/rfcc_mac.sv -----
`timescale 1ns / 1ps

module rfcc_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rfcc_pkg::t_emit     i_emit,
    input  rfcc_pkg::t_window   i_window,
    input  rfcc_pkg::t_cfg      i_cfg,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_stall,
    output rfcc_pkg::t_pixel    o_result,
    output logic                o_last
);

    typedef logic signed [rfcc_pkg::PROD_BITS-1:0] t_prod;
    typedef t_prod [rfcc_pkg::NUM_TAPS-1:0]        t_prod_row;
    typedef t_prod_row [rfcc_pkg::NCH-1:0]         t_prod_all;
    typedef logic signed [rfcc_pkg::ACC_BITS-1:0]  t_acc;
    typedef t_acc [rfcc_pkg::NCH-1:0]              t_acc_all;

    localparam t_acc RND_HALF = rfcc_pkg::ACC_BITS'(2 ** (rfcc_pkg::FRAC_BITS - 1));
    localparam t_acc SAT_MAX  = rfcc_pkg::ACC_BITS'(2 ** (rfcc_pkg::SAMPLE_BITS - 1) - 1);
    localparam t_acc SAT_MIN  = -SAT_MAX - rfcc_pkg::ACC_BITS'(1);

    logic             r_p_vld, r_p_last;
    t_prod_all        r_prod,  n_prod;
    logic             r_s_vld, r_s_last;
    t_acc_all         r_sum,   n_sum;
    logic             r_o_vld, r_o_last;
    rfcc_pkg::t_pixel r_o_data, n_o_data;

    logic take_o, take_s, take_p;
    logic [2:0] span;
    logic [2:0] widx;
    rfcc_pkg::t_tap    tap_s;
    rfcc_pkg::t_sample smp_s;
    t_acc              acc_r;
    t_acc              quot;

    assign take_o   = !r_o_vld || !i_stall;
    assign take_s   = !r_s_vld || take_o;
    assign take_p   = !r_p_vld || take_s;
    assign o_take   = take_p;
    assign o_valid  = r_o_vld;
    assign o_result = r_o_data;
    assign o_last   = r_o_last;
    assign span     = {i_cfg.half_width, 1'b0};

    // tap j meets window entry 2h-j, taps past 2h are dropped
    always_comb begin
        widx  = '0;
        tap_s = '0;
        smp_s = '0;
        for (int c = 0; c < rfcc_pkg::NCH; c++) begin
            for (int j = 0; j < rfcc_pkg::NUM_TAPS; j++) begin
                widx = span - 3'(j);
                if (3'(j) <= span) begin
                    tap_s = i_cfg.taps[j];
                    smp_s = i_window[widx][c];
                end else begin
                    tap_s = '0;
                    smp_s = '0;
                end
                n_prod[c][j] = tap_s * smp_s;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < rfcc_pkg::NCH; c++) begin
            n_sum[c] = '0;
            for (int j = 0; j < rfcc_pkg::NUM_TAPS; j++) begin
                n_sum[c] = n_sum[c] + rfcc_pkg::ACC_BITS'(r_prod[c][j]);
            end
        end
    end

    // round to nearest with ties upward, then saturate
    always_comb begin
        acc_r = '0;
        quot  = '0;
        for (int c = 0; c < rfcc_pkg::NCH; c++) begin
            acc_r = r_sum[c] + RND_HALF;
            quot  = acc_r >>> rfcc_pkg::FRAC_BITS;
            if (quot > SAT_MAX) begin
                n_o_data[c] = SAT_MAX[rfcc_pkg::SAMPLE_BITS-1:0];
            end else if (quot < SAT_MIN) begin
                n_o_data[c] = SAT_MIN[rfcc_pkg::SAMPLE_BITS-1:0];
            end else begin
                n_o_data[c] = quot[rfcc_pkg::SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (take_p) begin
                r_p_vld <= i_emit.vld;
            end
            if (take_s) begin
                r_s_vld <= r_p_vld;
            end
            if (take_o) begin
                r_o_vld <= r_s_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_p && i_emit.vld) begin
            r_prod   <= n_prod;
            r_p_last <= i_emit.last;
        end
        if (take_s && r_p_vld) begin
            r_sum    <= n_sum;
            r_s_last <= r_p_last;
        end
        if (take_o && r_s_vld) begin
            r_o_data <= n_o_data;
            r_o_last <= r_s_last;
        end
    end

endmodule
